// ===== rtl/rtc_datetime_to_epoch_core_macros.svh =====
// assertion helpers shared by the rtc date core
`ifndef RTC_DATETIME_TO_EPOCH_CORE_MACROS_SVH
`define RTC_DATETIME_TO_EPOCH_CORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define RDTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define RDTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdte_pkg.sv =====
package rdte_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BINARY_MODE     = 2'd0;
    localparam logic [1:0] CFG_HOUR_24         = 2'd1;
    localparam logic [1:0] CFG_CENTURY_PRESENT = 2'd2;

    localparam logic [7:0]  YEAR_PIVOT      = 8'd90;
    localparam logic [14:0] BASE_2000       = 15'd2000;
    localparam logic [14:0] BASE_1900       = 15'd1900;
    localparam logic [14:0] EPOCH_YEAR      = 15'd1970;
    localparam logic [14:0] LEAP4_ORIGIN    = 15'd1969;
    localparam logic [14:0] LEAP100_ORIGIN  = 15'd1901;
    localparam logic [14:0] LEAP400_ORIGIN  = 15'd1601;
    localparam logic [7:0]  NOON            = 8'd12;
    localparam logic [7:0]  MONTHS_PER_YEAR = 8'd12;
    // floor(x / 100) = (x * 20972) >> 21, exact for x below 2^15
    localparam logic [14:0] DIV100_MUL      = 15'd20972;

    typedef struct packed {
        logic binary_mode;
        logic hour_24;
        logic century_present;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [14:0] year;
    } t_fields;

    typedef struct packed {
        t_fields     f;
        logic [8:0]  year_div100;
        logic [12:0] leap_div4;
        logic [8:0]  leap_div100;
        logic [6:0]  leap_div400;
        logic [19:0] day_secs;
        logic        range_err;
    } t_s2;

    typedef struct packed {
        t_fields     f;
        logic        leap;
        logic        range_err;
        logic [19:0] day_secs;
        logic [24:0] days;
    } t_s3;

    typedef struct packed {
        t_fields     f;
        logic        leap;
        logic        range_err;
        logic [37:0] epoch;
    } t_res;

    function automatic logic [7:0] byte_value(input logic [7:0] b, input logic bin);
        logic [7:0] dec;
        dec = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
        return bin ? b : dec;
    endfunction

    function automatic logic [8:0] div100(input logic [14:0] x);
        logic [29:0] p;
        p = x * DIV100_MUL;
        return p[29:21];
    endfunction

    // days before the first of the month, zero for months that mean nothing
    function automatic logic [8:0] days_before(input logic [7:0] month, input logic leap);
        logic [8:0] d;
        case (month)
            8'd1:    d = 9'd0;
            8'd2:    d = 9'd31;
            8'd3:    d = 9'd59;
            8'd4:    d = 9'd90;
            8'd5:    d = 9'd120;
            8'd6:    d = 9'd151;
            8'd7:    d = 9'd181;
            8'd8:    d = 9'd212;
            8'd9:    d = 9'd243;
            8'd10:   d = 9'd273;
            8'd11:   d = 9'd304;
            8'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (month >= 8'd3) && (month <= MONTHS_PER_YEAR)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

// ===== rtl/rdte_decode_stage.sv =====
module rdte_decode_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rdte_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_raw_second,
    input  logic [7:0]            i_raw_minute,
    input  logic [7:0]            i_raw_hour,
    input  logic [7:0]            i_raw_day,
    input  logic [7:0]            i_raw_month,
    input  logic [7:0]            i_raw_year,
    input  logic [7:0]            i_raw_century,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rdte_pkg::t_fields     o_data
);

    logic              r_valid;
    rdte_pkg::t_fields r_data;
    rdte_pkg::t_fields n_data;
    logic [7:0]        hour_12;
    logic [7:0]        yr;
    logic [7:0]        cen;
    logic [15:0]       cen_year;

    always_comb begin
        n_data.second = rdte_pkg::byte_value(i_raw_second, i_cfg.binary_mode);
        n_data.minute = rdte_pkg::byte_value(i_raw_minute, i_cfg.binary_mode);
        n_data.day    = rdte_pkg::byte_value(i_raw_day, i_cfg.binary_mode);
        n_data.month  = rdte_pkg::byte_value(i_raw_month, i_cfg.binary_mode);

        // pm flag stripped before decode, 12 am/pm folded to 0 then pm adds 12
        hour_12 = rdte_pkg::byte_value({1'b0, i_raw_hour[6:0]}, i_cfg.binary_mode);
        if (hour_12 == rdte_pkg::NOON) begin
            hour_12 = 8'd0;
        end
        if (i_raw_hour[7]) begin
            hour_12 = hour_12 + rdte_pkg::NOON;
        end
        n_data.hour = i_cfg.hour_24 ? rdte_pkg::byte_value(i_raw_hour, i_cfg.binary_mode)
                                    : hour_12;

        yr       = rdte_pkg::byte_value(i_raw_year, i_cfg.binary_mode);
        cen      = rdte_pkg::byte_value(i_raw_century, i_cfg.binary_mode);
        cen_year = {8'd0, cen} * 16'd100 + {8'd0, yr};
        if (i_cfg.century_present) begin
            n_data.year = cen_year[14:0];
        end else if (yr < rdte_pkg::YEAR_PIVOT) begin
            n_data.year = rdte_pkg::BASE_2000 + {7'd0, yr};
        end else begin
            n_data.year = rdte_pkg::BASE_1900 + {7'd0, yr};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rdte_year_stage.sv =====
module rdte_year_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rdte_pkg::t_fields i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rdte_pkg::t_s2     o_data
);

    logic          r_valid;
    rdte_pkg::t_s2 r_data;
    rdte_pkg::t_s2 n_data;
    logic [14:0]   y4;
    logic [14:0]   y100;
    logic [14:0]   y400;
    logic [8:0]    q400;

    always_comb begin
        // leap day counts since 1970, offsets keep the floors non-negative
        y4   = i_data.year - rdte_pkg::LEAP4_ORIGIN;
        y100 = i_data.year - rdte_pkg::LEAP100_ORIGIN;
        y400 = i_data.year - rdte_pkg::LEAP400_ORIGIN;
        q400 = rdte_pkg::div100({2'b00, y400[14:2]});

        n_data.f           = i_data;
        n_data.year_div100 = rdte_pkg::div100(i_data.year);
        n_data.leap_div4   = y4[14:2];
        n_data.leap_div100 = rdte_pkg::div100(y100);
        n_data.leap_div400 = q400[6:0];
        n_data.day_secs    = {12'd0, i_data.hour} * 20'd3600
                           + {12'd0, i_data.minute} * 20'd60
                           + {12'd0, i_data.second};
        n_data.range_err   = (i_data.month == 8'd0)
                          || (i_data.month > rdte_pkg::MONTHS_PER_YEAR)
                          || (i_data.year < rdte_pkg::EPOCH_YEAR);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rdte_days_stage.sv =====
module rdte_days_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rdte_pkg::t_s2 i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rdte_pkg::t_s3 o_data
);

    logic          r_valid;
    rdte_pkg::t_s3 r_data;
    rdte_pkg::t_s3 n_data;
    logic [14:0]   rem100;
    logic [14:0]   years;
    logic          leap;
    logic [8:0]    dbm;

    always_comb begin
        rem100 = i_data.f.year - {6'd0, i_data.year_div100} * 15'd100;
        leap   = ((i_data.f.year[1:0] == 2'd0) && (rem100 != 15'd0))
              || ((rem100 == 15'd0) && (i_data.year_div100[1:0] == 2'd0));
        dbm    = rdte_pkg::days_before(i_data.f.month, leap);
        years  = i_data.f.year - rdte_pkg::EPOCH_YEAR;

        n_data.f         = i_data.f;
        n_data.leap      = leap;
        n_data.range_err = i_data.range_err;
        n_data.day_secs  = i_data.day_secs;
        // day 0 of january 1970 gives -1, kept as two's complement
        n_data.days      = {10'd0, years} * 25'd365
                         + {12'd0, i_data.leap_div4}
                         - {16'd0, i_data.leap_div100}
                         + {18'd0, i_data.leap_div400}
                         + {16'd0, dbm}
                         + {17'd0, i_data.f.day}
                         - 25'd1;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rdte_epoch_stage.sv =====
module rdte_epoch_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rdte_pkg::t_s3  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rdte_pkg::t_res o_data
);

    logic           r_valid;
    rdte_pkg::t_res r_data;
    rdte_pkg::t_res n_data;
    logic signed [42:0] day_prod;

    always_comb begin
        day_prod = $signed(i_data.days) * $signed(18'sd86400);

        n_data.f         = i_data.f;
        n_data.leap      = i_data.leap;
        n_data.range_err = i_data.range_err;
        n_data.epoch     = i_data.range_err ? 38'd0
                         : day_prod[37:0] + {18'd0, i_data.day_secs};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rtc_datetime_to_epoch_core.sv =====
// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_raw_second .. i_raw_century, 8 bits each
// result    out        o_valid / i_ready         decoded fields, year, leap, epoch, error
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index (2 bits), i_cfg_data (1 bit)
//
// four register stages: decode, year math, day count, epoch multiply
// one transfer per cycle sustained while i_ready stays high, the result registered in each stage in turn
// each stage holds its own valid bit and moves when the next one has room,
// so a stall at the output backs up stage by stage and bubbles are squeezed out
// synchronous active-low reset clears valid bits and loads the config defaults
// config is always ready; indexes beyond the register list are dropped
`include "rtc_datetime_to_epoch_core_macros.svh"

module rtc_datetime_to_epoch_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,

    // input transfer
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_raw_second,
    input  logic [7:0]  i_raw_minute,
    input  logic [7:0]  i_raw_hour,
    input  logic [7:0]  i_raw_day,
    input  logic [7:0]  i_raw_month,
    input  logic [7:0]  i_raw_year,
    input  logic [7:0]  i_raw_century,

    // result transfer
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_second_out,
    output logic [7:0]  o_minute_out,
    output logic [7:0]  o_hour_out,
    output logic [7:0]  o_day_out,
    output logic [7:0]  o_month_out,
    output logic [14:0] o_full_year,
    output logic        o_leap_year,
    output logic [37:0] o_epoch_seconds,
    output logic        o_range_error
);

    // config registers
    rdte_pkg::t_cfg r_cfg;

    // stage handshakes
    logic              w_s1_valid;
    logic              w_s1_ready;
    rdte_pkg::t_fields w_s1_data;
    logic              w_s2_valid;
    logic              w_s2_ready;
    rdte_pkg::t_s2     w_s2_data;
    logic              w_s3_valid;
    logic              w_s3_ready;
    rdte_pkg::t_s3     w_s3_data;
    rdte_pkg::t_res    w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.binary_mode     <= 1'b0;
            r_cfg.hour_24         <= 1'b1;
            r_cfg.century_present <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rdte_pkg::CFG_BINARY_MODE:     r_cfg.binary_mode     <= i_cfg_data;
                rdte_pkg::CFG_HOUR_24:         r_cfg.hour_24         <= i_cfg_data;
                rdte_pkg::CFG_CENTURY_PRESENT: r_cfg.century_present <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // stage 1: bcd or binary decode, 12h to 24h, full year
    rdte_decode_stage u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_second  (i_raw_second),
        .i_raw_minute  (i_raw_minute),
        .i_raw_hour    (i_raw_hour),
        .i_raw_day     (i_raw_day),
        .i_raw_month   (i_raw_month),
        .i_raw_year    (i_raw_year),
        .i_raw_century (i_raw_century),
        .o_valid       (w_s1_valid),
        .i_ready       (w_s1_ready),
        .o_data        (w_s1_data)
    );

    // stage 2: divide-by-100 reciprocals, leap day terms, seconds of day, range check
    rdte_year_stage u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    // stage 3: leap flag, day of year, days since the epoch
    rdte_days_stage u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2_data),
        .o_valid (w_s3_valid),
        .i_ready (w_s3_ready),
        .o_data  (w_s3_data)
    );

    // stage 4: days times 86400 plus seconds of day (zero on a range error), output register
    rdte_epoch_stage u_epoch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s3_valid),
        .o_ready (w_s3_ready),
        .i_data  (w_s3_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_res)
    );

    assign o_second_out    = w_res.f.second;
    assign o_minute_out    = w_res.f.minute;
    assign o_hour_out      = w_res.f.hour;
    assign o_day_out       = w_res.f.day;
    assign o_month_out     = w_res.f.month;
    assign o_full_year     = w_res.f.year;
    assign o_leap_year     = w_res.leap;
    assign o_epoch_seconds = w_res.epoch;
    assign o_range_error   = w_res.range_err;

    // an accepted transfer always lands in the first stage
    `RDTE_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && o_ready, w_s1_valid, "accepted transfer lost at stage 1")

    // an out-of-range date never carries a timestamp
    `RDTE_ASSERT_NOW(a_err_zero_epoch, i_clk, i_rst_n, o_valid && o_range_error, o_epoch_seconds == 38'd0, "epoch nonzero with range error")

    // no error flag means month and year were in range
    `RDTE_ASSERT_NOW(a_err_consistent, i_clk, i_rst_n, o_valid && !o_range_error, (o_month_out != 8'd0) && (o_month_out <= 8'd12) && (o_full_year >= 15'd1970), "range error flag missed")

    // a leap year is always a multiple of four
    `RDTE_ASSERT_NOW(a_leap_div4, i_clk, i_rst_n, o_valid && o_leap_year, o_full_year[1:0] == 2'd0, "leap flag on year not divisible by four")

endmodule

// ===== bench/tb_rtc_datetime_to_epoch_core.sv =====
module tb_rtc_datetime_to_epoch_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rdte_pkg::*;

    // index past the end of the register list, writes to it are dropped
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    localparam int          DATES_PER_SETTING = 112;
    localparam int          PIPE_LATENCY      = 4;
    localparam int unsigned CYCLE_LIMIT       = 200000;
    localparam logic [63:0] EPOCH_MASK        = 64'h3F_FFFF_FFFF;

    // first day of each month counted from jan 1, non-leap year, index 1..12
    localparam int unsigned MONTH_START [13] =
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // one set of raw clock register bytes
    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } t_raw_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_raw_second = '0;
    logic [7:0]  i_raw_minute = '0;
    logic [7:0]  i_raw_hour = '0;
    logic [7:0]  i_raw_day = '0;
    logic [7:0]  i_raw_month = '0;
    logic [7:0]  i_raw_year = '0;
    logic [7:0]  i_raw_century = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_second_out;
    logic [7:0]  o_minute_out;
    logic [7:0]  o_hour_out;
    logic [7:0]  o_day_out;
    logic [7:0]  o_month_out;
    logic [14:0] o_full_year;
    logic        o_leap_year;
    logic [37:0] o_epoch_seconds;
    logic        o_range_error;

    rtc_datetime_to_epoch_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_raw_second    (i_raw_second),
        .i_raw_minute    (i_raw_minute),
        .i_raw_hour      (i_raw_hour),
        .i_raw_day       (i_raw_day),
        .i_raw_month     (i_raw_month),
        .i_raw_year      (i_raw_year),
        .i_raw_century   (i_raw_century),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_second_out    (o_second_out),
        .o_minute_out    (o_minute_out),
        .o_hour_out      (o_hour_out),
        .o_day_out       (o_day_out),
        .o_month_out     (o_month_out),
        .o_full_year     (o_full_year),
        .o_leap_year     (o_leap_year),
        .o_epoch_seconds (o_epoch_seconds),
        .o_range_error   (o_range_error)
    );

    // date sets waiting for the driver, predicted conversions waiting for the monitor
    t_raw_date date_sets [$];
    t_res      predicted_dates [$];

    // register values as the block holds them, reset defaults
    t_cfg cfg_now = '{binary_mode: 1'b0, hour_24: 1'b1, century_present: 1'b0};

    t_raw_date   cur_date;
    bit          sending = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned dates_queued = 0;
    int unsigned dates_sent = 0;
    int unsigned dates_checked = 0;
    int unsigned settings_seen = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;

    // register byte to value, bcd nibbles above 9 are not rejected
    function automatic int unsigned reg_value(input logic [7:0] b, input logic bin);
        return bin ? int'(b) : int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    // value to register byte in the current coding
    function automatic logic [7:0] reg_byte(input int unsigned v, input logic bin);
        int unsigned tens;
        int unsigned ones;
        tens = v / 10;
        ones = v % 10;
        return bin ? v[7:0] : {tens[3:0], ones[3:0]};
    endfunction

    // predicted conversion of one date set under the given register values
    function automatic t_res convert_date(input t_raw_date d, input t_cfg c);
        t_res              r;
        int unsigned       sec;
        int unsigned       mins;
        int unsigned       hr;
        int unsigned       dy;
        int unsigned       mon;
        int unsigned       yr;
        int unsigned       cen;
        int unsigned       year;
        bit                leap;
        bit                err;
        longint unsigned   ty;
        longint unsigned   yday;
        logic [63:0]       secs;
        sec  = reg_value(d.second, c.binary_mode);
        mins = reg_value(d.minute, c.binary_mode);
        dy   = reg_value(d.day, c.binary_mode);
        mon  = reg_value(d.month, c.binary_mode);
        yr   = reg_value(d.year, c.binary_mode);
        cen  = reg_value(d.century, c.binary_mode);
        if (c.hour_24) begin
            hr = reg_value(d.hour, c.binary_mode);
        end else begin
            // pm flag stripped before decode, 12 o'clock folds to 0 first
            hr = reg_value({1'b0, d.hour[6:0]}, c.binary_mode);
            if (hr == 12) begin
                hr = 0;
            end
            if (d.hour[7]) begin
                hr = hr + 12;
            end
        end
        if (c.century_present) begin
            year = (cen * 100 + yr) & 32'h7FFF;
        end else begin
            year = (yr < 90) ? 2000 + yr : 1900 + yr;
        end
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        err  = (mon < 1) || (mon > 12) || (year < 1970);
        secs = '0;
        if (!err) begin
            ty   = year - 1900;
            yday = MONTH_START[mon];
            if (leap && mon >= 3) begin
                yday = yday + 1;
            end
            // day 0 goes one below, the whole sum wraps
            yday = yday + dy - 64'd1;
            secs = 64'(sec) + 64'(mins) * 64'd60 + 64'(hr) * 64'd3600
                 + yday * 64'd86400
                 + (ty - 64'd70) * 64'd31536000
                 + ((ty - 64'd69) / 64'd4) * 64'd86400
                 - ((ty - 64'd1) / 64'd100) * 64'd86400
                 + ((ty + 64'd299) / 64'd400) * 64'd86400;
            secs = secs & EPOCH_MASK;
        end
        r.f.second   = sec[7:0];
        r.f.minute   = mins[7:0];
        r.f.hour     = hr[7:0];
        r.f.day      = dy[7:0];
        r.f.month    = mon[7:0];
        r.f.year     = year[14:0];
        r.leap       = leap;
        r.range_err  = err;
        r.epoch      = secs[37:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // mostly well-formed dates in the active coding, the rest raw noise bytes
    function automatic t_raw_date random_date(input t_cfg c);
        t_raw_date   d;
        logic [63:0] noise;
        int unsigned hr;
        if ($urandom_range(99) < 25) begin
            noise = {$urandom, $urandom};
            d = noise[55:0];
            return d;
        end
        d.second = reg_byte($urandom_range(59), c.binary_mode);
        d.minute = reg_byte($urandom_range(59), c.binary_mode);
        if (c.hour_24) begin
            d.hour = reg_byte($urandom_range(23), c.binary_mode);
        end else begin
            hr = $urandom_range(12, 1);
            d.hour = reg_byte(hr, c.binary_mode) | ($urandom_range(1) ? 8'h80 : 8'h00);
        end
        d.day   = reg_byte($urandom_range(31, 1), c.binary_mode);
        d.month = reg_byte($urandom_range(12, 1), c.binary_mode);
        d.year  = reg_byte($urandom_range(99), c.binary_mode);
        if (c.century_present && $urandom_range(99) < 80) begin
            d.century = reg_byte($urandom_range(20, 19), c.binary_mode);
        end else if (c.century_present) begin
            d.century = reg_byte($urandom_range(99), c.binary_mode);
        end else begin
            d.century = 8'($urandom);
        end
        return d;
    endfunction

    task automatic queue_date(input logic [7:0] sec, input logic [7:0] mins,
                              input logic [7:0] hr, input logic [7:0] dy,
                              input logic [7:0] mon, input logic [7:0] yr,
                              input logic [7:0] cen);
        date_sets.push_back({sec, mins, hr, dy, mon, yr, cen});
        dates_queued++;
    endtask

    task automatic queue_random(input int n);
        repeat (n) begin
            date_sets.push_back(random_date(cfg_now));
            dates_queued++;
        end
    endtask

    // hold off new work until every queued date set has come back
    task automatic drain();
        while (dates_checked != dates_queued) begin
            @(posedge i_clk);
        end
    endtask

    // one register write, the local copy follows on the transfer edge
    task automatic set_reg(input logic [1:0] idx, input logic val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_BINARY_MODE:     cfg_now.binary_mode = val;
            CFG_HOUR_24:         cfg_now.hour_24 = val;
            CFG_CENTURY_PRESENT: cfg_now.century_present = val;
            default:             ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        set_reg(CFG_BINARY_MODE, c.binary_mode);
        set_reg(CFG_HOUR_24, c.hour_24);
        set_reg(CFG_CENTURY_PRESENT, c.century_present);
        settings_seen++;
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // input side: takes the next date set off the queue, holds it until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sending = 1'b0;
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predicted_dates.push_back(convert_date(cur_date, cfg_now));
                dates_sent++;
                sending = 1'b0;
            end
            // a new set goes out only after the previous transfer, so valid
            // is assigned once per edge and never dropped while waiting
            if (!sending && date_sets.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                cur_date = date_sets.pop_front();
                sending = 1'b1;
                i_raw_second  <= cur_date.second;
                i_raw_minute  <= cur_date.minute;
                i_raw_hour    <= cur_date.hour;
                i_raw_day     <= cur_date.day;
                i_raw_month   <= cur_date.month;
                i_raw_year    <= cur_date.year;
                i_raw_century <= cur_date.century;
            end
            i_valid <= sending;
        end
    end

    // result side: random back-pressure, each transfer checked against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (predicted_dates.size() == 0) begin
                    $error("result transfer with no date set outstanding");
                    mismatch_cnt++;
                end else begin
                    want = predicted_dates.pop_front();
                    check_field("second_out", want.f.second, o_second_out);
                    check_field("minute_out", want.f.minute, o_minute_out);
                    check_field("hour_out", want.f.hour, o_hour_out);
                    check_field("day_out", want.f.day, o_day_out);
                    check_field("month_out", want.f.month, o_month_out);
                    check_field("full_year", want.f.year, o_full_year);
                    check_field("leap_year", want.leap, o_leap_year);
                    check_field("epoch_seconds", want.epoch, o_epoch_seconds);
                    check_field("range_error", want.range_err, o_range_error);
                    dates_checked++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_cfg c;
        logic [2:0] setting;

        // first idling mix: slow sender, very slow receiver
        send_idle_pct = 35;
        recv_idle_pct = 86;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_seen = 1;

        // reset defaults: bcd bytes, 24-hour, century guessed
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h00);  // epoch start
        queue_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70, 8'h00);  // day 0, wraps below 0
        queue_date(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h00);  // 2069 year end
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h90, 8'h00);  // pivot year, 1990
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h89, 8'h00);  // just below pivot
        queue_date(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h00);  // feb 29 of 2000
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24, 8'h00);  // march in a leap year
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h24, 8'h00);  // month 0
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h24, 8'h00);  // month 13
        queue_date(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // every nibble 15
        queue_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        // write past the register list, must change nothing
        set_reg(CFG_NO_REG, 1'b1);
        queue_date(8'h30, 8'h15, 8'h12, 8'h15, 8'h06, 8'h25, 8'hFF);
        drain();

        // 12-hour mode: midnight, noon, 1 pm, pm flag over 0x7f
        set_reg(CFG_HOUR_24, 1'b0);
        queue_date(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h70, 8'h00);
        queue_date(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h70, 8'h00);
        queue_date(8'h00, 8'h00, 8'h81, 8'h01, 8'h01, 8'h70, 8'h00);
        queue_date(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h70, 8'h00);
        drain();

        // century byte in use: 1999, a date before 1970, a non-leap and a leap century
        set_reg(CFG_CENTURY_PRESENT, 1'b1);
        queue_date(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h99, 8'h19);
        queue_date(8'h59, 8'h59, 8'h11, 8'h31, 8'h12, 8'h69, 8'h19);
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21);
        queue_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h24);
        drain();

        // binary bytes: largest year overflows 38 bits, pm noon, zeros
        set_reg(CFG_BINARY_MODE, 1'b1);
        queue_date(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0C, 8'hFF, 8'hFF);
        queue_date(8'h3B, 8'h3B, 8'h8C, 8'h1F, 8'h0C, 8'h63, 8'h13);
        queue_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        // binary 24-hour with a guessed century: raw hour 255, years around the pivot
        set_reg(CFG_HOUR_24, 1'b1);
        set_reg(CFG_CENTURY_PRESENT, 1'b0);
        queue_date(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h5A, 8'h00);
        queue_date(8'h00, 8'h00, 8'h17, 8'h01, 8'h01, 8'h59, 8'h00);
        drain();
        settings_seen = settings_seen + 5;

        // random part: every register combination, idling mix moves by thirds
        for (int s = 0; s < 8; s++) begin
            case (s * 3 / 8)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            setting = s[2:0];
            c = setting;
            apply_cfg(c);
            queue_random(DATES_PER_SETTING / 2);
            // sender holds off mid-setting until the pipe is empty
            drain();
            queue_random(DATES_PER_SETTING - DATES_PER_SETTING / 2);
            drain();
        end

        // tail: catch any stray result after the last one
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (predicted_dates.size() != 0) begin
            $error("%0d predicted results never came out", predicted_dates.size());
            mismatch_cnt++;
        end

        $display("run summary: %0d date sets sent, %0d results compared, %0d mismatches",
                 dates_sent, dates_checked, mismatch_cnt);
        $display("covered bcd/binary bytes, 12/24-hour, given/guessed century, %0d settings",
                 settings_seen);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rdte_pkg.sv
rtl/rdte_decode_stage.sv
rtl/rdte_year_stage.sv
rtl/rdte_days_stage.sv
rtl/rdte_epoch_stage.sv
rtl/rtc_datetime_to_epoch_core.sv
bench/tb_rtc_datetime_to_epoch_core.sv
